FILE: rtl/core/lfu_pkg.sv
// Shared types and constants for the LFU cache controller.
// Depends on nothing; the interfaces and top level import it.
package lfu_pkg;

  // Field widths fixed by the request and response formats.
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 16;
  localparam int CFG_W = 5;

  // Largest use count; a use at this value saturates.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Value returned by a get that misses.
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

  // Request operation codes.
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE
  } lfu_state_e;

endpackage

FILE: rtl/core/lfu_if.sv
// Request and response channel interfaces of the LFU cache controller.
// Depends on lfu_pkg for the field widths.
interface lfu_req_if;
  import lfu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

FILE: rtl/core/lfu_store.sv
// Entry storage of the LFU cache: one write port, one registered read port.
// Depends on nothing; the entry layout is set by the instantiating module.
module lfu_store #(
  parameter int DEPTH = 16,
  parameter int DW    = 84,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/lfu_cache_controller.sv
// LFU cache controller with least-recently-used tie-break, top level.
// Depends on lfu_pkg, the lfu_req_if and lfu_rsp_if interfaces and lfu_store.
//
// A request on req carries kind (get or put), key and value; each request
// yields exactly one response on rsp with hit and read_value. A get hit
// returns the stored value, a get miss returns -1 and a put returns 0.
// The user writes the capacity register (cfg_we_i, cfg_wdata_i) only while
// the block is idle (it does not enforce this); values above CAPACITY are clamped.
//
// Each request is handled by one sequencer that walks the entry memory one
// entry per cycle through its single read port: a scan pass finds the key,
// the first free slot and the eviction victim, then an update pass rewrites
// ranks and counts. The response is registered at the decision step after the
// scan pass. req.ready is high again after the update pass when the entries
// change, and once the decision step is done for a get miss or a put at
// capacity zero.
// The response register holds its response until rsp.ready; a stalled
// receiver holds the sequencer at its decision step, so nothing is lost.
// Reset empties the cache and sets the capacity to min(16, CAPACITY).
module lfu_cache_controller #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lfu_pkg::CFG_W-1:0]   cfg_wdata_i,
  lfu_req_if.sink                     req,
  lfu_rsp_if.source                   rsp
);
  import lfu_pkg::*;

  localparam int IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW      = $clog2(CAPACITY + 1);
  localparam int CMPW    = (PW > CFG_W) ? PW : CFG_W;
  localparam int CAP_LIM = (CAPACITY < 31) ? CAPACITY : 31;
  localparam int CAP_RST = (CAPACITY < 16) ? CAPACITY : 16;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] cnt;
    logic [IW-1:0]    rank;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // Control state.
  lfu_state_e          state_q, state_d;
  logic [PW-1:0]       ptr_q, ptr_d;
  logic                rd_vld_q, rd_vld_d;
  logic [IW-1:0]       rd_idx_q, rd_idx_d;
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [PW-1:0]       occ_q, occ_d;
  logic [CFG_W-1:0]    cap_q, cap_d;
  logic                rsp_valid_q, rsp_valid_d;

  // Request and scan results.
  logic                op_kind_q, op_kind_d;
  logic [KEY_W-1:0]    op_key_q, op_key_d;
  logic [VAL_W-1:0]    op_val_q, op_val_d;
  logic                found_q, found_d;
  logic [IW-1:0]       e_idx_q, e_idx_d;
  logic [VAL_W-1:0]    e_val_q, e_val_d;
  logic [IW-1:0]       e_rank_q, e_rank_d;
  logic                free_found_q, free_found_d;
  logic [IW-1:0]       free_idx_q, free_idx_d;
  logic                vic_found_q, vic_found_d;
  logic [IW-1:0]       vic_idx_q, vic_idx_d;
  logic [CNT_W-1:0]    vic_cnt_q, vic_cnt_d;
  logic [IW-1:0]       vic_rank_q, vic_rank_d;
  logic                ins_q, ins_d;
  logic                evict_q, evict_d;
  logic [IW-1:0]       slot_q, slot_d;
  logic                rsp_hit_q, rsp_hit_d;
  logic [VAL_W-1:0]    rsp_val_q, rsp_val_d;

  // Memory ports.
  logic          rd_en;
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_ent;
  entry_t        rd_ent;
  logic          ent_v;
  logic          last;
  logic          do_evict;
  logic          slot_ok;
  logic [IW-1:0] slot_pick;

  lfu_store #(
    .DEPTH (CAPACITY),
    .DW    (EW),
    .AW    (IW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q[IW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_ent)
  );

  assign rd_ent = entry_t'(rd_data);
  assign ent_v  = valid_q[rd_idx_q];
  assign last   = rd_vld_q && (rd_idx_q == IW'(CAPACITY - 1));

  // Handshake outputs.
  assign req.ready      = (state_q == ST_IDLE);
  assign rsp.valid      = rsp_valid_q;
  assign rsp.hit        = rsp_hit_q;
  assign rsp.read_value = rsp_val_q;

  // Replacement decision for a put that misses.
  always_comb begin
    do_evict  = (CMPW'(occ_q) >= CMPW'(cap_q)) && vic_found_q;
    slot_pick = free_idx_q;
    slot_ok   = free_found_q;
    if (do_evict) begin
      slot_ok = 1'b1;
      if (!free_found_q || (vic_idx_q < free_idx_q)) begin
        slot_pick = vic_idx_q;
      end
    end
  end

  // Sequencer: next state, scan bookkeeping and entry rewrites.
  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    valid_d      = valid_q;
    occ_d        = occ_q;
    cap_d        = cap_q;
    op_kind_d    = op_kind_q;
    op_key_d     = op_key_q;
    op_val_d     = op_val_q;
    found_d      = found_q;
    e_idx_d      = e_idx_q;
    e_val_d      = e_val_q;
    e_rank_d     = e_rank_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    vic_found_d  = vic_found_q;
    vic_idx_d    = vic_idx_q;
    vic_cnt_d    = vic_cnt_q;
    vic_rank_d   = vic_rank_q;
    ins_d        = ins_q;
    evict_d      = evict_q;
    slot_d       = slot_q;
    rsp_hit_d    = rsp_hit_q;
    rsp_val_d    = rsp_val_q;
    rsp_valid_d  = rsp_valid_q && !rsp.ready;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = rd_idx_q;
    wr_ent       = rd_ent;

    // Capacity register, clamped to the number of slots.
    if (cfg_we_i) begin
      cap_d = (int'(cfg_wdata_i) > CAP_LIM) ? CFG_W'(CAP_LIM) : cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          op_kind_d    = req.kind;
          op_key_d     = req.key;
          op_val_d     = req.value;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          vic_found_d  = 1'b0;
          ptr_d        = '0;
          state_d      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        rd_en = (ptr_q < PW'(CAPACITY));
        if (rd_en) begin
          ptr_d = ptr_q + PW'(1);
        end
        if (rd_vld_q) begin
          // First valid entry with a matching key.
          if (ent_v && !found_q && (rd_ent.key == op_key_q)) begin
            found_d  = 1'b1;
            e_idx_d  = rd_idx_q;
            e_val_d  = rd_ent.value;
            e_rank_d = rd_ent.rank;
          end
          // Lowest free slot.
          if (!ent_v && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = rd_idx_q;
          end
          // Victim: smallest count, then the oldest touch.
          if (ent_v && (!vic_found_q || (rd_ent.cnt < vic_cnt_q) ||
              ((rd_ent.cnt == vic_cnt_q) && (rd_ent.rank > vic_rank_q)))) begin
            vic_found_d = 1'b1;
            vic_idx_d   = rd_idx_q;
            vic_cnt_d   = rd_ent.cnt;
            vic_rank_d  = rd_ent.rank;
          end
        end
        if (last) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (!rsp_valid_q || rsp.ready) begin
          rsp_valid_d = 1'b1;
          rsp_hit_d   = found_q;
          ptr_d       = '0;
          ins_d       = 1'b0;
          evict_d     = do_evict;
          slot_d      = slot_pick;
          state_d     = ST_IDLE;
          if (op_kind_q == KIND_GET) begin
            rsp_val_d = found_q ? e_val_q : MISS_VALUE;
            if (found_q) begin
              state_d = ST_UPDATE;
            end
          end else begin
            rsp_val_d = '0;
            if (cap_q != '0) begin
              if (found_q) begin
                state_d = ST_UPDATE;
              end else if (slot_ok) begin
                ins_d   = 1'b1;
                state_d = ST_UPDATE;
              end
            end
          end
        end
      end

      ST_UPDATE: begin
        rd_en = (ptr_q < PW'(CAPACITY));
        if (rd_en) begin
          ptr_d = ptr_q + PW'(1);
        end
        if (rd_vld_q) begin
          if (!ins_q) begin
            // Touch: the hit entry becomes the youngest, younger ones age.
            wr_en = ent_v;
            if (rd_idx_q == e_idx_q) begin
              wr_ent.rank = '0;
              if (rd_ent.cnt != CNT_MAX) begin
                wr_ent.cnt = rd_ent.cnt + CNT_W'(1);
              end
              if (op_kind_q == KIND_PUT) begin
                wr_ent.value = op_val_q;
              end
            end else if (rd_ent.rank < e_rank_q) begin
              wr_ent.rank = rd_ent.rank + IW'(1);
            end
          end else begin
            // Insert, after removing the victim when the cache is full.
            if (rd_idx_q == slot_q) begin
              wr_en        = 1'b1;
              wr_ent.key   = op_key_q;
              wr_ent.value = op_val_q;
              wr_ent.cnt   = CNT_W'(1);
              wr_ent.rank  = '0;
              valid_d[rd_idx_q] = 1'b1;
            end else if (evict_q && (rd_idx_q == vic_idx_q)) begin
              valid_d[rd_idx_q] = 1'b0;
            end else if (ent_v) begin
              wr_en = 1'b1;
              if (evict_q && (rd_ent.rank > vic_rank_q)) begin
                wr_ent.rank = rd_ent.rank;
              end else begin
                wr_ent.rank = rd_ent.rank + IW'(1);
              end
            end
          end
        end
        if (last) begin
          if (ins_q) begin
            occ_d = evict_q ? occ_q : occ_q + PW'(1);
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_vld_d = rd_en;
  assign rd_idx_d = ptr_q[IW-1:0];

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      cap_q       <= CFG_W'(CAP_RST);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      rd_vld_q    <= rd_vld_d;
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      cap_q       <= cap_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload and scan result registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    op_kind_q    <= op_kind_d;
    op_key_q     <= op_key_d;
    op_val_q     <= op_val_d;
    found_q      <= found_d;
    e_idx_q      <= e_idx_d;
    e_val_q      <= e_val_d;
    e_rank_q     <= e_rank_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    vic_found_q  <= vic_found_d;
    vic_idx_q    <= vic_idx_d;
    vic_cnt_q    <= vic_cnt_d;
    vic_rank_q   <= vic_rank_d;
    ins_q        <= ins_d;
    evict_q      <= evict_d;
    slot_q       <= slot_d;
    rsp_hit_q    <= rsp_hit_d;
    rsp_val_q    <= rsp_val_d;
  end

endmodule

FILE: tb/sv/lfu_cache_controller_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LFU cache controller with LRU tie-break.
// Depends on lfu_pkg, the lfu_req_if and lfu_rsp_if interfaces and the RTL top level.
module lfu_cache_controller_tb;
  import lfu_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int REST_CYCLES = 2 * CAPACITY + 8;
  localparam int STUCK_LIMIT = 1000;
  localparam int PHASE_LEN   = 200;
  localparam int POOL_SIZE   = 24;

  typedef struct {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct {
    logic             hit;
    logic [VAL_W-1:0] read_value;
  } reply_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  lfu_req_if req_ch ();
  lfu_rsp_if rsp_ch ();

  lfu_cache_controller #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_ch.sink),
    .rsp        (rsp_ch.source)
  );

  always #4 clk_i = ~clk_i;

  // Requests waiting to be driven and replies waiting to be checked.
  request_t request_queue[$];
  reply_t   expected_replies[$];

  // Shadow copy of the cache contents used for prediction.
  logic             m_valid[CAPACITY];
  logic [KEY_W-1:0] m_key[CAPACITY];
  logic [VAL_W-1:0] m_value[CAPACITY];
  logic [CNT_W-1:0] m_count[CAPACITY];
  logic [3:0]       m_rank[CAPACITY];
  logic [4:0]       m_occupied;
  logic [CFG_W-1:0] m_capacity;

  // Run control and statistics.
  int idle_pct;
  int fail_count;
  int get_count;
  int put_count;
  int hit_count;
  int settings_seen;
  int send_gap;
  int stall_left;
  int stuck_cycles;

  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) begin
      $display("%0t ns ERROR %s", $time, msg);
    end
    fail_count++;
  endtask

  // Make an entry the most recently touched and count the use, saturating.
  function automatic void touch_entry(input int e);
    logic [3:0] r;
    r = m_rank[e];
    for (int i = 0; i < CAPACITY; i++) begin
      if (m_valid[i] && i != e && m_rank[i] < r) begin
        m_rank[i]++;
      end
    end
    m_rank[e] = '0;
    if (m_count[e] != CNT_MAX) begin
      m_count[e]++;
    end
  endfunction

  // Apply one request to the shadow cache and return the reply it must produce.
  function automatic void cache_access(input logic kind, input logic [KEY_W-1:0] k,
                                       input logic [VAL_W-1:0] v, output reply_t ans);
    int         e;
    int         vic;
    int         slot;
    logic [3:0] r;
    e = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (e < 0 && m_valid[i] && m_key[i] == k) begin
        e = i;
      end
    end
    ans.hit        = (e >= 0);
    ans.read_value = '0;
    if (kind == KIND_GET) begin
      if (e >= 0) begin
        touch_entry(e);
        ans.read_value = m_value[e];
      end else begin
        ans.read_value = MISS_VALUE;
      end
    end else if (m_capacity != 0) begin
      if (e >= 0) begin
        m_value[e] = v;
        touch_entry(e);
      end else begin
        // A full store first drops the least used entry, oldest on a tie.
        if (m_occupied >= m_capacity) begin
          vic = -1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (m_valid[i] && (vic < 0 || m_count[i] < m_count[vic] ||
                (m_count[i] == m_count[vic] && m_rank[i] > m_rank[vic]))) begin
              vic = i;
            end
          end
          if (vic >= 0) begin
            r = m_rank[vic];
            m_valid[vic] = 1'b0;
            for (int i = 0; i < CAPACITY; i++) begin
              if (m_valid[i] && m_rank[i] > r) begin
                m_rank[i]--;
              end
            end
            if (m_occupied != 0) begin
              m_occupied--;
            end
          end
        end
        // The new key goes into the lowest free slot as the youngest entry.
        slot = -1;
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot < 0 && !m_valid[i]) begin
            slot = i;
          end
        end
        if (slot >= 0) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (m_valid[i]) begin
              m_rank[i]++;
            end
          end
          m_valid[slot] = 1'b1;
          m_key[slot]   = k;
          m_value[slot] = v;
          m_count[slot] = CNT_W'(1);
          m_rank[slot]  = '0;
          m_occupied++;
        end
      end
    end
  endfunction

  // Request driver: presents queued requests, with random bursts of idle cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    request_t nxt;
    reply_t   ans;
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.kind  <= KIND_GET;
      req_ch.key   <= '0;
      req_ch.value <= '0;
      send_gap     <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        cache_access(req_ch.kind, req_ch.key, req_ch.value, ans);
        expected_replies.push_back(ans);
        if (req_ch.kind == KIND_GET) begin
          get_count++;
        end else begin
          put_count++;
        end
        if (ans.hit) begin
          hit_count++;
        end
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap     <= send_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (request_queue.size() != 0 && idle_pct != 0 &&
                     $urandom_range(99) < idle_pct) begin
          send_gap     <= $urandom_range(0, 11);
          req_ch.valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          nxt = request_queue.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.kind  <= nxt.kind;
          req_ch.key   <= nxt.key;
          req_ch.value <= nxt.value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each reply against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t exp_r;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply hit=%0b value=%h with no request outstanding",
                                    rsp_ch.hit, rsp_ch.read_value));
        end else begin
          exp_r = expected_replies.pop_front();
          if (rsp_ch.hit !== exp_r.hit) begin
            report_mismatch($sformatf("hit is %b, predicted %b", rsp_ch.hit, exp_r.hit));
          end
          if (rsp_ch.read_value !== exp_r.read_value) begin
            report_mismatch($sformatf("read_value is %h, predicted %h",
                                      rsp_ch.read_value, exp_r.read_value));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        stall_left   <= $urandom_range(0, 11);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if work is pending and nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (request_queue.size() == 0 && expected_replies.size() == 0 && !req_ch.valid)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Timed out after %0d cycles without a handshake.", STUCK_LIMIT);
      $display("lfu_cache_controller: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic queue_request(input logic kind, input logic [KEY_W-1:0] k,
                               input logic [VAL_W-1:0] v);
    request_t it;
    it.kind  = kind;
    it.key   = k;
    it.value = v;
    request_queue.push_back(it);
  endtask

  // Wait until every request has been answered and the block has finished its update.
  task automatic drain_and_rest();
    do begin
      @(negedge clk_i);
    end while (request_queue.size() != 0 || req_ch.valid || expected_replies.size() != 0);
    repeat (REST_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] w);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    m_capacity = (w > CAPACITY) ? CFG_W'(CAPACITY) : w;
    settings_seen++;
    @(negedge clk_i);
  endtask

  // Random traffic: mostly keys from a small pool so that hits and evictions occur.
  task automatic run_random_phase(input logic [CFG_W-1:0] cap, input int idle);
    int               span;
    logic [KEY_W-1:0] k;
    write_capacity(cap);
    idle_pct = idle;
    span = (m_capacity < 5) ? 8 : int'(m_capacity) + 4;
    if (span > POOL_SIZE) begin
      span = POOL_SIZE;
    end
    for (int n = 0; n < PHASE_LEN; n++) begin
      if ($urandom_range(99) < 5) begin
        key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
      end
      if ($urandom_range(99) < 85) begin
        k = key_pool[$urandom_range(0, span - 1)];
      end else begin
        k = $urandom;
      end
      queue_request($urandom_range(1) ? KIND_PUT : KIND_GET, k, $urandom);
    end
    drain_and_rest();
  endtask

  // Main sequence: reset, directed cases, then random phases at several capacities.
  initial begin
    req_ch.valid = 1'b0;
    req_ch.kind  = KIND_GET;
    req_ch.key   = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      m_valid[i] = 1'b0;
      m_key[i]   = '0;
      m_value[i] = '0;
      m_count[i] = '0;
      m_rank[i]  = '0;
    end
    m_occupied    = '0;
    m_capacity    = CFG_W'(CAPACITY);
    idle_pct      = 0;
    fail_count    = 0;
    get_count     = 0;
    put_count     = 0;
    hit_count     = 0;
    settings_seen = 0;
    stuck_cycles  = 0;
    key_pool[0] = 32'h7fff_ffff;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Extreme keys and values at the reset capacity, update of a present key.
    idle_pct = 10;
    queue_request(KIND_GET, 32'h7fff_ffff, 32'h1111_1111);
    queue_request(KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
    queue_request(KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
    queue_request(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_request(KIND_PUT, 32'hffff_ffff, 32'hffff_ffff);
    queue_request(KIND_GET, 32'h7fff_ffff, 32'h0);
    queue_request(KIND_GET, 32'h8000_0000, 32'hffff_ffff);
    queue_request(KIND_GET, 32'hffff_ffff, 32'h0);
    queue_request(KIND_PUT, 32'h0000_0000, 32'h1357_9bdf);
    queue_request(KIND_GET, 32'h0000_0000, 32'h0);
    queue_request(KIND_GET, 32'h1234_5678, 32'h0);
    drain_and_rest();

    // Capacity below occupancy: a tie on the use count, then a lone least used entry.
    write_capacity(5'd3);
    queue_request(KIND_PUT, 32'h0000_0100, 32'h0000_0001);
    queue_request(KIND_GET, 32'h7fff_ffff, 32'h0);
    queue_request(KIND_PUT, 32'h0000_0200, 32'h0000_0002);
    queue_request(KIND_GET, 32'h0000_0100, 32'h0);
    queue_request(KIND_GET, 32'h0000_0200, 32'h0);
    drain_and_rest();

    // Capacity zero: puts change nothing but still report presence.
    write_capacity(5'd0);
    queue_request(KIND_PUT, 32'h0000_0200, 32'h0000_0005);
    queue_request(KIND_PUT, 32'h0000_0300, 32'h0000_0006);
    queue_request(KIND_GET, 32'h0000_0200, 32'h0);
    queue_request(KIND_GET, 32'h0000_0300, 32'h0);
    drain_and_rest();

    // Register value above the number of entries is clamped.
    write_capacity(5'd31);
    queue_request(KIND_PUT, 32'h0000_0400, 32'hdead_beef);
    queue_request(KIND_GET, 32'h0000_0400, 32'h0);
    drain_and_rest();

    run_random_phase(5'd16, 15);
    run_random_phase(5'd1, 25);
    run_random_phase(5'd4, 0);
    run_random_phase(5'd0, 20);
    run_random_phase(5'd17, 10);
    run_random_phase(5'd31, 30);
    run_random_phase(5'd7, 15);
    run_random_phase(5'd2, 20);
    run_random_phase(5'd16, 25);
    run_random_phase(5'd16, 0);

    if (expected_replies.size() != 0) begin
      report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));
    end
    $display("Checked %0d gets and %0d puts (%0d hits) under %0d capacity settings,",
             get_count, put_count, hit_count, settings_seen);
    $display("including eviction ties, a shrunken capacity, capacity zero and clamping.");
    if (fail_count == 0) begin
      $display("lfu_cache_controller: match");
    end else begin
      $display("lfu_cache_controller: mismatch");
    end
    $finish;
  end

endmodule
